FILE: rtl/multi_servo_slew_controller_assert.svh
// Assertion macros shared by the servo slew controller RTL.
`ifndef MULTI_SERVO_SLEW_CONTROLLER_ASSERT_SVH
`define MULTI_SERVO_SLEW_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MSSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MSSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mssc_pkg.sv
// Package with the types, codes and constants of the servo slew controller.
package mssc_pkg;

	localparam int SERVO_COUNT_DEF = 8;
	localparam int MAX_RESULTS     = 8;
	localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam int ANGLE_W = 8;
	localparam int PULSE_W = 12;
	localparam int SPEED_W = 5;
	localparam int CFG_W   = 12;

	localparam logic [SPEED_W-1:0] SPEED_MIN = 5'd1;
	localparam logic [SPEED_W-1:0] SPEED_MAX = 5'd20;

	// Reset values of the registers and the servo state.
	localparam logic [ANGLE_W-1:0] RST_MIN_ANGLE  = 8'd0;
	localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE  = 8'd180;
	localparam logic [PULSE_W-1:0] RST_MIN_PULSE  = 12'd500;
	localparam logic [PULSE_W-1:0] RST_MAX_PULSE  = 12'd2500;
	localparam logic [ANGLE_W-1:0] RST_HOME_ANGLE = 8'd90;
	localparam logic [SPEED_W-1:0] RST_DEF_SPEED  = 5'd2;

	// Numerator of the interpolation: off * dp + span / 2 fits in 20 bits.
	localparam int NUM_W  = ANGLE_W + PULSE_W;
	localparam int DIV_CW = $clog2(NUM_W + 1);

	typedef enum logic [2:0] {
		CFG_MIN_ANGLE  = 3'd0,
		CFG_MAX_ANGLE  = 3'd1,
		CFG_MIN_PULSE  = 3'd2,
		CFG_MAX_PULSE  = 3'd3,
		CFG_HOME_ANGLE = 3'd4,
		CFG_DEF_SPEED  = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_MOVE_TO   = 3'd1,
		CMD_SET_SPEED = 3'd2,
		CMD_STOP_ALL  = 3'd3,
		CMD_HOME_ALL  = 3'd4,
		CMD_HOME_ONE  = 3'd5,
		CMD_QUERY     = 3'd6,
		CMD_START     = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SINGLE,
		ST_SINGLE_OUT,
		ST_SUMMARY,
		ST_SCAN,
		ST_PULSE_WAIT
	} seq_state_t;

	typedef enum logic [1:0] {
		PU_IDLE,
		PU_MUL,
		PU_DIV,
		PU_DONE
	} pulse_state_t;

	// Shared limits seen by the pulse unit.
	typedef struct packed {
		logic [ANGLE_W-1:0] min_angle;
		logic [ANGLE_W-1:0] max_angle;
		logic [PULSE_W-1:0] min_pulse;
		logic [PULSE_W-1:0] max_pulse;
	} pulse_cfg_t;

endpackage

FILE: rtl/mssc_pulse.sv
// Pulse width unit: one multiply, then a bit-serial restoring divide.
module mssc_pulse (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mssc_pkg::pulse_cfg_t             cfg,
	input  logic                             start,
	input  logic [mssc_pkg::ANGLE_W-1:0]     angle_in,
	output logic                             done,
	output logic [mssc_pkg::PULSE_W-1:0]     pulse
);

	mssc_pkg::pulse_state_t state_q, state_d;

	logic [mssc_pkg::ANGLE_W-1:0] ang_c, span_c, off_c;
	logic [mssc_pkg::PULSE_W-1:0] dp_c;
	logic                         flat_c, down_c;

	logic [mssc_pkg::ANGLE_W-1:0] off_q, span_q;
	logic [mssc_pkg::PULSE_W-1:0] dp_q, base_q, res_c;
	logic                         flat_q, down_q;
	logic [mssc_pkg::NUM_W-1:0]   num_q, quo_q;
	logic [mssc_pkg::ANGLE_W:0]   rem_q;
	logic [mssc_pkg::DIV_CW-1:0]  cnt_q;

	logic [mssc_pkg::ANGLE_W:0]   rem_sh;
	logic                         sub_ok;
	logic [mssc_pkg::NUM_W-1:0]   quo_nx;
	logic [mssc_pkg::PULSE_W-1:0] q12;

	// Clamp the angle into the limits and form span, offset and pulse range.
	always_comb begin
		flat_c = (cfg.max_angle <= cfg.min_angle);
		ang_c  = angle_in;
		if (ang_c < cfg.min_angle) ang_c = cfg.min_angle;
		if (ang_c > cfg.max_angle) ang_c = cfg.max_angle;
		span_c = cfg.max_angle - cfg.min_angle;
		off_c  = ang_c - cfg.min_angle;
		down_c = (cfg.max_pulse < cfg.min_pulse);
		dp_c   = down_c ? (cfg.min_pulse - cfg.max_pulse) : (cfg.max_pulse - cfg.min_pulse);
	end

	// One restoring divide step on the shifted remainder.
	always_comb begin
		rem_sh = {rem_q[mssc_pkg::ANGLE_W-1:0], num_q[mssc_pkg::NUM_W-1]};
		sub_ok = (rem_sh >= {1'b0, span_q});
		quo_nx = {quo_q[mssc_pkg::NUM_W-2:0], sub_ok};
		q12    = quo_q[mssc_pkg::PULSE_W-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mssc_pkg::PU_IDLE: if (start) state_d = flat_c ? mssc_pkg::PU_DONE : mssc_pkg::PU_MUL;
			mssc_pkg::PU_MUL:  state_d = mssc_pkg::PU_DIV;
			mssc_pkg::PU_DIV:  if (cnt_q == mssc_pkg::DIV_CW'(mssc_pkg::NUM_W - 1))
				state_d = mssc_pkg::PU_DONE;
			mssc_pkg::PU_DONE: if (start) state_d = flat_c ? mssc_pkg::PU_DONE : mssc_pkg::PU_MUL;
			default:           state_d = mssc_pkg::PU_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mssc_pkg::PU_IDLE;
		else         state_q <= state_d;
	end

	// Datapath registers of the multiply and the divide.
	always_ff @(posedge clk) begin
		if (start) begin
			off_q  <= off_c;
			span_q <= span_c;
			dp_q   <= dp_c;
			down_q <= down_c;
			flat_q <= flat_c;
			base_q <= cfg.min_pulse;
		end
		case (state_q)
			mssc_pkg::PU_MUL: begin
				num_q <= mssc_pkg::NUM_W'(off_q) * mssc_pkg::NUM_W'(dp_q) +
				         mssc_pkg::NUM_W'(span_q >> 1);
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			mssc_pkg::PU_DIV: begin
				num_q <= {num_q[mssc_pkg::NUM_W-2:0], 1'b0};
				rem_q <= sub_ok ? (rem_sh - {1'b0, span_q}) : rem_sh;
				quo_q <= quo_nx;
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Result: min pulse when the limits are flat, else min plus or minus q.
	always_comb begin
		if (flat_q)      res_c = base_q;
		else if (down_q) res_c = base_q - q12;
		else             res_c = base_q + q12;
	end

	assign done  = (state_q == mssc_pkg::PU_DONE) && !start;
	assign pulse = res_c;

endmodule

FILE: rtl/multi_servo_slew_controller.sv
// Top level of the multi servo slew controller: servo state, sequencer, output register.
//
//  channel  direction  handshake               payload
//  in       input      in_valid / in_ready     command, servo_id, angle, speed
//  out      output     out_valid / out_ready   out_servo .. last
//  cfg      input      cfg_we                  cfg_index, cfg_data
//
// A tick or start first updates every servo, one per cycle, then walks the servos
// again and runs the shared pulse unit for each result: launch, one multiply, 20 divide
// steps, then the result.
// Single-servo commands act on their servo and then give one result; stop_all and home_all update every servo.
// Reset loads the home state at once.
// A stalled output holds the sequencer at its next result.
`include "multi_servo_slew_controller_assert.svh"

module multi_servo_slew_controller #(
	parameter int SERVO_COUNT = mssc_pkg::SERVO_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_index,
	input  logic [mssc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       command,
	input  logic [7:0]                       servo_id,
	input  logic [7:0]                       angle,
	input  logic [7:0]                       speed,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_servo,
	output logic [mssc_pkg::PULSE_W-1:0]     pulse_us,
	output logic [mssc_pkg::ANGLE_W-1:0]     angle_now,
	output logic [mssc_pkg::ANGLE_W-1:0]     angle_target,
	output logic [mssc_pkg::SPEED_W-1:0]     step_now,
	output logic                             is_moving,
	output logic                             accepted,
	output logic                             any_moving,
	output logic                             last
);

	localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SERVO_COUNT - 1);

	// Configuration registers.
	logic [mssc_pkg::ANGLE_W-1:0] min_angle_q, max_angle_q, home_angle_q;
	logic [mssc_pkg::PULSE_W-1:0] min_pulse_q, max_pulse_q;
	logic [mssc_pkg::SPEED_W-1:0] def_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q  <= mssc_pkg::RST_MIN_ANGLE;
			max_angle_q  <= mssc_pkg::RST_MAX_ANGLE;
			min_pulse_q  <= mssc_pkg::RST_MIN_PULSE;
			max_pulse_q  <= mssc_pkg::RST_MAX_PULSE;
			home_angle_q <= mssc_pkg::RST_HOME_ANGLE;
			def_speed_q  <= mssc_pkg::RST_DEF_SPEED;
		end else if (cfg_we) begin
			case (cfg_index)
				mssc_pkg::CFG_MIN_ANGLE:  min_angle_q  <= cfg_data[mssc_pkg::ANGLE_W-1:0];
				mssc_pkg::CFG_MAX_ANGLE:  max_angle_q  <= cfg_data[mssc_pkg::ANGLE_W-1:0];
				mssc_pkg::CFG_MIN_PULSE:  min_pulse_q  <= cfg_data[mssc_pkg::PULSE_W-1:0];
				mssc_pkg::CFG_MAX_PULSE:  max_pulse_q  <= cfg_data[mssc_pkg::PULSE_W-1:0];
				mssc_pkg::CFG_HOME_ANGLE: home_angle_q <= cfg_data[mssc_pkg::ANGLE_W-1:0];
				mssc_pkg::CFG_DEF_SPEED:  def_speed_q  <= cfg_data[mssc_pkg::SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// Latched item and sequencer registers.
	mssc_pkg::seq_state_t state_q, state_d;
	mssc_pkg::cmd_t       cmd_q;
	logic [7:0]           id_q, ang_q, spd_q;
	logic                 idv_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SERVO_COUNT-1:0] mask_q, mask_clr;
	logic [mssc_pkg::RES_CNT_W-1:0] n_q;

	// Servo state.
	logic [mssc_pkg::ANGLE_W-1:0] cur_q [SERVO_COUNT];
	logic [mssc_pkg::ANGLE_W-1:0] tgt_q [SERVO_COUNT];
	logic [mssc_pkg::SPEED_W-1:0] spd_st_q [SERVO_COUNT];
	logic [SERVO_COUNT-1:0]       mv_q;

	// Output register.
	logic                         out_valid_q;
	logic [7:0]                   o_servo_q;
	logic [mssc_pkg::PULSE_W-1:0] o_pulse_q;
	logic [mssc_pkg::ANGLE_W-1:0] o_now_q, o_tgt_q;
	logic [mssc_pkg::SPEED_W-1:0] o_spd_q;
	logic                         o_mv_q, o_acc_q, o_any_q, o_last_q;

	logic in_acc, out_free, id_ok, cmd_single;
	logic pu_start, pu_done;
	logic [mssc_pkg::PULSE_W-1:0] pu_pulse;
	mssc_pkg::pulse_cfg_t pu_cfg;

	// Control decoded from the state.
	logic upd_en, single_en, load_single, load_summary, load_pulse, scan_step, res_last;

	assign in_acc     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign id_ok      = (servo_id < 8'(SERVO_COUNT));
	assign cmd_single = (command == mssc_pkg::CMD_MOVE_TO || command == mssc_pkg::CMD_SET_SPEED ||
	                     command == mssc_pkg::CMD_HOME_ONE || command == mssc_pkg::CMD_QUERY);

	// Selected servo and the arithmetic on it.
	logic [mssc_pkg::ANGLE_W-1:0] cur_s, tgt_s, mag_s, step_cur, clamp_in, clamp_out;
	logic [mssc_pkg::SPEED_W-1:0] spd_s, def_clamp, req_clamp;
	logic                         step_done;

	always_comb begin
		cur_s = cur_q[idx_q];
		tgt_s = tgt_q[idx_q];
		spd_s = spd_st_q[idx_q];
		mag_s = (tgt_s >= cur_s) ? (tgt_s - cur_s) : (cur_s - tgt_s);
		step_done = (mag_s <= mssc_pkg::ANGLE_W'(spd_s));
		if (step_done)          step_cur = tgt_s;
		else if (tgt_s > cur_s) step_cur = cur_s + mssc_pkg::ANGLE_W'(spd_s);
		else                    step_cur = cur_s - mssc_pkg::ANGLE_W'(spd_s);
		// Target clamp tests the lower limit first.
		clamp_in = (cmd_q == mssc_pkg::CMD_MOVE_TO) ? ang_q : home_angle_q;
		if (clamp_in < min_angle_q)      clamp_out = min_angle_q;
		else if (clamp_in > max_angle_q) clamp_out = max_angle_q;
		else                             clamp_out = clamp_in;
		if (def_speed_q < mssc_pkg::SPEED_MIN)      def_clamp = mssc_pkg::SPEED_MIN;
		else if (def_speed_q > mssc_pkg::SPEED_MAX) def_clamp = mssc_pkg::SPEED_MAX;
		else                                        def_clamp = def_speed_q;
		if (spd_q < 8'(mssc_pkg::SPEED_MIN))      req_clamp = mssc_pkg::SPEED_MIN;
		else if (spd_q > 8'(mssc_pkg::SPEED_MAX)) req_clamp = mssc_pkg::SPEED_MAX;
		else                                      req_clamp = spd_q[mssc_pkg::SPEED_W-1:0];
	end

	always_comb begin
		mask_clr = mask_q;
		mask_clr[idx_q] = 1'b0;
		res_last = (mask_clr == '0) || (n_q == mssc_pkg::RES_CNT_W'(mssc_pkg::MAX_RESULTS - 1));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mssc_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (cmd_single)
						state_d = mssc_pkg::ST_SINGLE;
					else
						state_d = mssc_pkg::ST_UPDATE;
				end
			end
			mssc_pkg::ST_UPDATE: begin
				if (idx_q == IDX_LAST) begin
					if (cmd_q == mssc_pkg::CMD_START)
						state_d = mssc_pkg::ST_SCAN;
					else if (cmd_q == mssc_pkg::CMD_TICK && ((mask_q | mv_q) != '0))
						state_d = mssc_pkg::ST_SCAN;
					else
						state_d = mssc_pkg::ST_SUMMARY;
				end
			end
			mssc_pkg::ST_SINGLE:     state_d = mssc_pkg::ST_SINGLE_OUT;
			mssc_pkg::ST_SINGLE_OUT: if (out_free) state_d = mssc_pkg::ST_IDLE;
			mssc_pkg::ST_SUMMARY:    if (out_free) state_d = mssc_pkg::ST_IDLE;
			mssc_pkg::ST_SCAN:       if (mask_q[idx_q]) state_d = mssc_pkg::ST_PULSE_WAIT;
			mssc_pkg::ST_PULSE_WAIT: begin
				if (pu_done && out_free)
					state_d = res_last ? mssc_pkg::ST_IDLE : mssc_pkg::ST_SCAN;
			end
			default: state_d = mssc_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready     = (state_q == mssc_pkg::ST_IDLE);
		upd_en       = (state_q == mssc_pkg::ST_UPDATE);
		single_en    = (state_q == mssc_pkg::ST_SINGLE) && idv_q;
		load_single  = (state_q == mssc_pkg::ST_SINGLE_OUT) && out_free;
		load_summary = (state_q == mssc_pkg::ST_SUMMARY) && out_free;
		scan_step    = (state_q == mssc_pkg::ST_SCAN) && !mask_q[idx_q];
		pu_start     = (state_q == mssc_pkg::ST_SCAN) && mask_q[idx_q];
		load_pulse   = (state_q == mssc_pkg::ST_PULSE_WAIT) && pu_done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mssc_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Item latch, servo index, result mask and result count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q  <= mssc_pkg::CMD_TICK;
			idv_q  <= 1'b0;
			idx_q  <= '0;
			mask_q <= '0;
			n_q    <= '0;
		end else begin
			if (in_acc) begin
				cmd_q  <= mssc_pkg::cmd_t'(command);
				idv_q  <= id_ok;
				idx_q  <= (id_ok && cmd_single) ? servo_id[IDX_W-1:0] : '0;
				mask_q <= '0;
				n_q    <= '0;
			end
			if (upd_en) begin
				mask_q[idx_q] <= (cmd_q == mssc_pkg::CMD_START) ||
				                 (cmd_q == mssc_pkg::CMD_TICK && mv_q[idx_q]);
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			end
			if (scan_step) idx_q <= idx_q + 1'b1;
			if (load_pulse) begin
				mask_q <= mask_clr;
				n_q    <= n_q + 1'b1;
				if (idx_q != IDX_LAST) idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q  <= servo_id;
			ang_q <= angle;
			spd_q <= speed;
		end
	end

	// Servo state updates, one servo per cycle at the current index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SERVO_COUNT; i++) begin
				cur_q[i]    <= mssc_pkg::RST_HOME_ANGLE;
				tgt_q[i]    <= mssc_pkg::RST_HOME_ANGLE;
				spd_st_q[i] <= mssc_pkg::RST_DEF_SPEED;
			end
			mv_q <= '0;
		end else if (upd_en) begin
			case (cmd_q)
				mssc_pkg::CMD_TICK: begin
					if (mv_q[idx_q]) begin
						cur_q[idx_q] <= step_cur;
						if (step_done) mv_q[idx_q] <= 1'b0;
					end
				end
				mssc_pkg::CMD_START: begin
					cur_q[idx_q]    <= home_angle_q;
					tgt_q[idx_q]    <= home_angle_q;
					spd_st_q[idx_q] <= def_clamp;
					mv_q[idx_q]     <= 1'b0;
				end
				mssc_pkg::CMD_STOP_ALL: begin
					tgt_q[idx_q] <= cur_s;
					mv_q[idx_q]  <= 1'b0;
				end
				mssc_pkg::CMD_HOME_ALL: begin
					tgt_q[idx_q] <= clamp_out;
					mv_q[idx_q]  <= (cur_s != clamp_out);
				end
				default: ;
			endcase
		end else if (single_en) begin
			case (cmd_q)
				mssc_pkg::CMD_MOVE_TO, mssc_pkg::CMD_HOME_ONE: begin
					tgt_q[idx_q] <= clamp_out;
					mv_q[idx_q]  <= (cur_s != clamp_out);
				end
				mssc_pkg::CMD_SET_SPEED: spd_st_q[idx_q] <= req_clamp;
				default: ;
			endcase
		end
	end

	// Shared pulse unit.
	assign pu_cfg = '{min_angle: min_angle_q, max_angle: max_angle_q,
	                  min_pulse: min_pulse_q, max_pulse: max_pulse_q};

	mssc_pulse u_pulse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (pu_cfg),
		.start    (pu_start),
		.angle_in (cur_s),
		.done     (pu_done),
		.pulse    (pu_pulse)
	);

	// Output register: loaded once per result, held while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_single || load_summary || load_pulse) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_single) begin
			o_servo_q <= id_q;
			o_pulse_q <= '0;
			o_now_q   <= idv_q ? cur_s : '0;
			o_tgt_q   <= idv_q ? tgt_s : '0;
			o_spd_q   <= idv_q ? spd_s : '0;
			o_mv_q    <= idv_q && mv_q[idx_q];
			o_acc_q   <= idv_q;
			o_any_q   <= |mv_q;
			o_last_q  <= 1'b1;
		end else if (load_summary) begin
			o_servo_q <= '0;
			o_pulse_q <= '0;
			o_now_q   <= '0;
			o_tgt_q   <= '0;
			o_spd_q   <= '0;
			o_mv_q    <= 1'b0;
			o_acc_q   <= 1'b1;
			o_any_q   <= |mv_q;
			o_last_q  <= 1'b1;
		end else if (load_pulse) begin
			o_servo_q <= 8'(idx_q);
			o_pulse_q <= pu_pulse;
			o_now_q   <= cur_s;
			o_tgt_q   <= tgt_s;
			o_spd_q   <= spd_s;
			o_mv_q    <= mv_q[idx_q];
			o_acc_q   <= 1'b1;
			o_any_q   <= |mv_q;
			o_last_q  <= res_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_servo    = o_servo_q;
	assign pulse_us     = o_pulse_q;
	assign angle_now    = o_now_q;
	assign angle_target = o_tgt_q;
	assign step_now     = o_spd_q;
	assign is_moving    = o_mv_q;
	assign accepted     = o_acc_q;
	assign any_moving   = o_any_q;
	assign last         = o_last_q;

	// A result is only ever emitted for a servo still pending in the mask.
	`MSSC_ASSERT_NOW(a_pulse_masked, load_pulse, mask_q[idx_q], "pulse result for unmasked servo")
	// No item emits more results than the cap.
	`MSSC_ASSERT_NOW(a_result_cap, state_q == mssc_pkg::ST_PULSE_WAIT,
		n_q < mssc_pkg::RES_CNT_W'(mssc_pkg::MAX_RESULTS), "result cap exceeded")
	// An accepted item always leaves the idle state.
	`MSSC_ASSERT_NEXT(a_busy_after_accept, in_acc, state_q != mssc_pkg::ST_IDLE,
		"sequencer stayed idle after an item")

endmodule

FILE: tb/sv/tb_multi_servo_slew_controller.sv
// Self-checking testbench for the multi servo slew controller.
module tb_multi_servo_slew_controller;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSERVO = 8;
	localparam int RANDOM_PER_PHASE = 38;
	localparam int SETTLE_CYCLES = NSERVO * 25 + 20;

	// One result as it leaves the block.
	typedef struct packed {
		logic [7:0]  servo;
		logic [11:0] pulse;
		logic [7:0]  now;
		logic [7:0]  tgt;
		logic [4:0]  spd;
		logic        mov;
		logic        acc;
		logic        any;
		logic        lst;
	} servo_result_t;

	// One directed item, with a typed expectation where it is obvious.
	typedef struct {
		mssc_pkg::cmd_t cmd;
		logic [7:0]     id;
		logic [7:0]     ang;
		logic [7:0]     spd;
		bit             typed;
		servo_result_t  res;
	} cmd_row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [mssc_pkg::CFG_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic [2:0] command;
	logic [7:0] servo_id, angle, speed;
	logic out_valid, out_ready;
	logic [7:0] out_servo;
	logic [mssc_pkg::PULSE_W-1:0] pulse_us;
	logic [mssc_pkg::ANGLE_W-1:0] angle_now, angle_target;
	logic [mssc_pkg::SPEED_W-1:0] step_now;
	logic is_moving, accepted, any_moving, last;

	multi_servo_slew_controller DUT (.*);

	// Predictor state: configuration and per-servo state.
	int unsigned lim_min_a, lim_max_a, lim_min_p, lim_max_p, home_pos, def_speed;
	int unsigned cur_ang[NSERVO], tgt_ang[NSERVO], spd_now[NSERVO];
	bit          moving[NSERVO];

	servo_result_t pending_results[$];
	int  errors, items_sent, results_seen, ticks_sent;
	int  send_idle_pct, recv_stall_pct;
	int  hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_multi_servo_slew_controller failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	function automatic int unsigned clamp_speed(input int unsigned s);
		if (s < 1) return 1;
		if (s > 20) return 20;
		return s;
	endfunction

	// Rounded interpolation of an angle onto the pulse range.
	function automatic logic [11:0] pulse_for(input int unsigned a);
		int unsigned span, off, dp, q;
		if (lim_max_a <= lim_min_a) return lim_min_p[11:0];
		if (a < lim_min_a) a = lim_min_a;
		if (a > lim_max_a) a = lim_max_a;
		span = lim_max_a - lim_min_a;
		off = a - lim_min_a;
		if (lim_max_p >= lim_min_p) begin
			dp = lim_max_p - lim_min_p;
			q = (off * dp + span / 2) / span;
			return 12'(lim_min_p + q);
		end
		dp = lim_min_p - lim_max_p;
		q = (off * dp + span / 2) / span;
		return 12'(lim_min_p - q);
	endfunction

	function automatic void aim_servo(input int unsigned i, input int unsigned a);
		if (a < lim_min_a) a = lim_min_a;
		else if (a > lim_max_a) a = lim_max_a;
		tgt_ang[i] = a;
		moving[i] = cur_ang[i] != tgt_ang[i];
	endfunction

	function automatic servo_result_t status_of(input int unsigned i, input logic [11:0] p);
		servo_result_t r;
		r = '0;
		r.servo = 8'(i);
		r.pulse = p;
		r.now = 8'(cur_ang[i]);
		r.tgt = 8'(tgt_ang[i]);
		r.spd = 5'(spd_now[i]);
		r.mov = moving[i];
		r.acc = 1'b1;
		return r;
	endfunction

	// Apply one command to the predictor and queue the results it causes.
	function automatic void predict_command(input mssc_pkg::cmd_t cmd, input logic [7:0] id,
			input logic [7:0] ang, input logic [7:0] spd, input bit typed,
			input servo_result_t typed_res);
		servo_result_t batch[$];
		servo_result_t r;
		bit any;
		int unsigned mag;
		case (cmd)
			mssc_pkg::CMD_TICK: begin
				for (int i = 0; i < NSERVO; i++) begin
					if (!moving[i]) continue;
					mag = tgt_ang[i] >= cur_ang[i] ? tgt_ang[i] - cur_ang[i]
						: cur_ang[i] - tgt_ang[i];
					if (mag <= spd_now[i]) begin
						cur_ang[i] = tgt_ang[i];
						moving[i] = 1'b0;
					end else if (tgt_ang[i] > cur_ang[i]) begin
						cur_ang[i] = (cur_ang[i] + spd_now[i]) & 8'hFF;
					end else begin
						cur_ang[i] = (cur_ang[i] - spd_now[i]) & 8'hFF;
					end
					batch.push_back(status_of(i, pulse_for(cur_ang[i])));
				end
			end
			mssc_pkg::CMD_START: begin
				for (int i = 0; i < NSERVO; i++) begin
					spd_now[i] = clamp_speed(def_speed);
					cur_ang[i] = home_pos;
					tgt_ang[i] = home_pos;
					moving[i] = 1'b0;
					batch.push_back(status_of(i, pulse_for(home_pos)));
				end
			end
			mssc_pkg::CMD_STOP_ALL: begin
				for (int i = 0; i < NSERVO; i++) begin
					tgt_ang[i] = cur_ang[i];
					moving[i] = 1'b0;
				end
			end
			mssc_pkg::CMD_HOME_ALL: begin
				for (int i = 0; i < NSERVO; i++) aim_servo(i, home_pos);
			end
			default: begin
				if (id < NSERVO) begin
					if (cmd == mssc_pkg::CMD_MOVE_TO) aim_servo(id, ang);
					else if (cmd == mssc_pkg::CMD_SET_SPEED) spd_now[id] = clamp_speed(spd);
					else if (cmd == mssc_pkg::CMD_HOME_ONE) aim_servo(id, home_pos);
					batch.push_back(status_of(id, 12'd0));
				end else begin
					r = '0;
					r.servo = id;
					batch.push_back(r);
				end
			end
		endcase
		// Summary result when nothing else was produced.
		if (batch.size() == 0) begin
			r = '0;
			r.acc = 1'b1;
			batch.push_back(r);
		end
		any = 1'b0;
		for (int i = 0; i < NSERVO; i++) any |= moving[i];
		foreach (batch[k]) begin
			batch[k].any = any;
			batch[k].lst = (k == batch.size() - 1);
		end
		if (typed) pending_results.push_back(typed_res);
		else foreach (batch[k]) pending_results.push_back(batch[k]);
	endfunction

	// Offer one item and wait for it to be taken.
	task automatic send_command(input mssc_pkg::cmd_t cmd, input logic [7:0] id,
			input logic [7:0] ang, input logic [7:0] spd, input bit typed,
			input servo_result_t typed_res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		servo_id <= id;
		angle <= ang;
		speed <= spd;
		do @(posedge clk); while (!in_ready);
		predict_command(cmd, id, ang, spd, typed, typed_res);
		items_sent++;
		if (cmd == mssc_pkg::CMD_TICK) ticks_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all six registers while the block is idle.
	task automatic load_limits(input int unsigned v[6]);
		for (int r = 0; r < 6; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(r);
			cfg_data <= 12'(v[r]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		lim_min_a = v[mssc_pkg::CFG_MIN_ANGLE] & 8'hFF;
		lim_max_a = v[mssc_pkg::CFG_MAX_ANGLE] & 8'hFF;
		lim_min_p = v[mssc_pkg::CFG_MIN_PULSE] & 12'hFFF;
		lim_max_p = v[mssc_pkg::CFG_MAX_PULSE] & 12'hFFF;
		home_pos = v[mssc_pkg::CFG_HOME_ANGLE] & 8'hFF;
		def_speed = v[mssc_pkg::CFG_DEF_SPEED] & 5'h1F;
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(99) >= recv_stall_pct;
			end
		end
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		servo_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {out_servo, pulse_us, angle_now, angle_target, step_now,
				is_moving, accepted, any_moving, last};
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", got));
			end else begin
				want = pending_results.pop_front();
				if (got.servo !== want.servo) report_mismatch(
					$sformatf("out_servo %0d, want %0d", got.servo, want.servo));
				if (got.pulse !== want.pulse) report_mismatch(
					$sformatf("pulse_us %0d, want %0d", got.pulse, want.pulse));
				if (got.now !== want.now) report_mismatch(
					$sformatf("angle_now %0d, want %0d", got.now, want.now));
				if (got.tgt !== want.tgt) report_mismatch(
					$sformatf("angle_target %0d, want %0d", got.tgt, want.tgt));
				if (got.spd !== want.spd) report_mismatch(
					$sformatf("step_now %0d, want %0d", got.spd, want.spd));
				if (got.mov !== want.mov) report_mismatch(
					$sformatf("is_moving %0b, want %0b", got.mov, want.mov));
				if (got.acc !== want.acc) report_mismatch(
					$sformatf("accepted %0b, want %0b", got.acc, want.acc));
				if (got.any !== want.any) report_mismatch(
					$sformatf("any_moving %0b, want %0b", got.any, want.any));
				if (got.lst !== want.lst) report_mismatch(
					$sformatf("last %0b, want %0b", got.lst, want.lst));
			end
		end
	end

	initial begin
		cmd_row_t rows[$];
		servo_result_t none;
		int unsigned limits[8][6];
		mssc_pkg::cmd_t cmd;
		logic [7:0] id, ang, spd;
		int pick;

		// Limit sets: reset values, extremes, equal and inverted limits.
		limits = '{
			'{0, 180, 500, 2500, 90, 2},
			'{0, 180, 0, 4000, 0, 20},
			'{180, 180, 4000, 0, 180, 1},
			'{120, 40, 1000, 3000, 200, 0},
			'{10, 170, 3000, 700, 255, 31},
			'{0, 255, 4095, 0, 45, 17},
			'{30, 150, 600, 2400, 91, 5},
			'{0, 180, 500, 2500, 90, 2}};

		none = '0;
		rows = '{
			'{mssc_pkg::CMD_QUERY, 0, 0, 0, 1, '{0, 0, 90, 90, 2, 0, 1, 0, 1}},
			'{mssc_pkg::CMD_QUERY, 200, 0, 0, 1, '{200, 0, 0, 0, 0, 0, 0, 0, 1}},
			'{mssc_pkg::CMD_TICK, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 1, 0, 1}},
			'{mssc_pkg::CMD_STOP_ALL, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 1, 0, 1}},
			'{mssc_pkg::CMD_MOVE_TO, 0, 255, 0, 0, none},
			'{mssc_pkg::CMD_MOVE_TO, 1, 0, 0, 0, none},
			'{mssc_pkg::CMD_MOVE_TO, 2, 37, 0, 0, none},
			'{mssc_pkg::CMD_SET_SPEED, 3, 0, 0, 0, none},
			'{mssc_pkg::CMD_SET_SPEED, 4, 0, 255, 0, none},
			'{mssc_pkg::CMD_SET_SPEED, 9, 0, 7, 1, '{9, 0, 0, 0, 0, 0, 0, 1, 1}},
			'{mssc_pkg::CMD_MOVE_TO, 255, 50, 0, 1, '{255, 0, 0, 0, 0, 0, 0, 1, 1}},
			'{mssc_pkg::CMD_MOVE_TO, 3, 180, 0, 0, none},
			'{mssc_pkg::CMD_MOVE_TO, 4, 1, 0, 0, none},
			'{mssc_pkg::CMD_HOME_ONE, 1, 0, 0, 0, none},
			'{mssc_pkg::CMD_TICK, 0, 0, 0, 0, none},
			'{mssc_pkg::CMD_TICK, 0, 0, 0, 0, none},
			'{mssc_pkg::CMD_QUERY, 0, 0, 0, 0, none},
			'{mssc_pkg::CMD_HOME_ALL, 0, 0, 0, 0, none},
			'{mssc_pkg::CMD_TICK, 0, 0, 0, 0, none},
			'{mssc_pkg::CMD_START, 0, 0, 0, 0, none},
			'{mssc_pkg::CMD_TICK, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 1, 0, 1}},
			'{mssc_pkg::CMD_QUERY, 7, 0, 0, 0, none},
			'{mssc_pkg::CMD_QUERY, 8, 0, 0, 1, '{8, 0, 0, 0, 0, 0, 0, 0, 1}},
			'{mssc_pkg::CMD_MOVE_TO, 5, 170, 0, 0, none},
			'{mssc_pkg::CMD_STOP_ALL, 0, 0, 0, 0, none}};

		errors = 0; items_sent = 0; results_seen = 0; ticks_sent = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; command = '0; servo_id = '0; angle = '0; speed = '0;

		// Predictor starts from the reset state.
		lim_min_a = mssc_pkg::RST_MIN_ANGLE; lim_max_a = mssc_pkg::RST_MAX_ANGLE;
		lim_min_p = mssc_pkg::RST_MIN_PULSE; lim_max_p = mssc_pkg::RST_MAX_PULSE;
		home_pos = mssc_pkg::RST_HOME_ANGLE; def_speed = mssc_pkg::RST_DEF_SPEED;
		for (int i = 0; i < NSERVO; i++) begin
			cur_ang[i] = mssc_pkg::RST_HOME_ANGLE;
			tgt_ang[i] = mssc_pkg::RST_HOME_ANGLE;
			spd_now[i] = mssc_pkg::RST_DEF_SPEED;
			moving[i] = 1'b0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items on the reset configuration.
		foreach (rows[r])
			send_command(rows[r].cmd, rows[r].id, rows[r].ang, rows[r].spd,
				rows[r].typed, rows[r].res);

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			load_limits(limits[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			// Long receiver hold-off so the block backs up into its input.
			if (ph == 4) hold_cycles = 600;
			send_command(mssc_pkg::CMD_START, 8'($urandom), 8'($urandom), 8'($urandom),
				0, none);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(NSERVO - 1));
				ang = 8'($urandom);
				spd = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(25));
				if (pick < 35) cmd = mssc_pkg::CMD_TICK;
				else if (pick < 62) cmd = mssc_pkg::CMD_MOVE_TO;
				else if (pick < 72) cmd = mssc_pkg::CMD_SET_SPEED;
				else if (pick < 77) cmd = mssc_pkg::CMD_STOP_ALL;
				else if (pick < 83) cmd = mssc_pkg::CMD_HOME_ALL;
				else if (pick < 89) cmd = mssc_pkg::CMD_HOME_ONE;
				else if (pick < 96) cmd = mssc_pkg::CMD_QUERY;
				else cmd = mssc_pkg::CMD_START;
				send_command(cmd, id, ang, spd, 0, none);
			end
		end

		wait_drained();
		$display("Run covered %0d items (%0d ticks) over 8 limit settings, %0d results checked.",
			items_sent, ticks_sent, results_seen);
		$display("Settings included equal, inverted and out-of-range limits and a long stall.");
		if (errors == 0) begin
			$display("tb_multi_servo_slew_controller passed");
		end else begin
			$display("tb_multi_servo_slew_controller failed");
		end
		$finish;
	end

endmodule
